// ===== rtl/assert_macros.svh =====
// assertion macros shared by the contrast stretch rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expr");

// antecedent now implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante then cons");

`endif

// ===== rtl/mmcs_pkg.sv =====
// types and constants of the min-max contrast stretch
// no dependencies; imported by every module of the block
package mmcs_pkg;

   localparam int unsigned LEVEL_W     = 9;
   localparam int unsigned PIXEL_W     = 24;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]         BIN_THRESHOLD = 8'd128;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 9'd256;
   localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT  = 9'd1;
   localparam logic [LEVEL_W-1:0] MIN_RESET     = 9'd256;
   localparam logic [LEVEL_W-1:0] MAX_RESET     = 9'd0;

   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_SCALE   = 1'b1;
   localparam logic MODE_GREY    = 1'b0;

   typedef struct packed {
      logic               kind;
      logic               last;
      logic [LEVEL_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } back_state_type;

endpackage

// ===== rtl/mmcs_front.sv =====
// front end: csr register, input transaction acceptance and level classification
// depends on mmcs_pkg
module mmcs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_kind,
   input  logic [mmcs_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                               req_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mmcs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mmcs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mmcs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   input  mmcs_pkg::queue_status_type         q_status,
   output logic                               q_push,
   output mmcs_pkg::item_type                 q_item
);
   import mmcs_pkg::*;

   logic       source_mode_ff;
   logic       source_mode_in;
   logic       csr_write;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       any_bright;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   // single register, every word offset maps onto it
   assign source_mode_in = (csr_write && (paddr == paddr)) ? pwdata[0] : source_mode_ff;
   assign prdata = {{(CSR_DATA_W-1){1'b0}}, source_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff <= MODE_GREY;
      end else begin
         source_mode_ff <= source_mode_in;
      end
   end

   assign red        = req_pixel[7:0];
   assign green      = req_pixel[15:8];
   assign blue       = req_pixel[23:16];
   assign any_bright = (red > BIN_THRESHOLD) || (green > BIN_THRESHOLD) ||
                       (blue > BIN_THRESHOLD);

   always_comb begin
      q_item.kind = req_kind;
      q_item.last = req_last;
      if (source_mode_ff == MODE_GREY) begin
         q_item.value = {1'b0, red};
      end else begin
         q_item.value = any_bright ? LEVEL_BRIGHT : LEVEL_ONE;
      end
   end

   assign full   = q_status.full;
   assign q_push = push & ~q_status.full;

endmodule

// ===== rtl/mmcs_queue.sv =====
// short in-order queue between the front end and the back end
// depends on mmcs_pkg and assert_macros.svh
module mmcs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mmcs_pkg::item_type         push_item,
   input  logic                       pop,
   output mmcs_pkg::item_type         head_item,
   output mmcs_pkg::queue_status_type status
);
   import mmcs_pkg::*;
   `include "assert_macros.svh"

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_ptr_track, clock, reset, QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])

endmodule

// ===== rtl/mmcs_back.sv =====
// back end: running min/max, serial restoring divider and result register
// depends on mmcs_pkg and assert_macros.svh
module mmcs_back #(
   parameter int unsigned OUT_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mmcs_pkg::queue_status_type q_status,
   input  mmcs_pkg::item_type         q_item,
   output logic                       q_pop,
   output logic                       empty,
   input  logic                       pop,
   output logic [OUT_FRAC_BITS:0]     rsp_level,
   output logic                       rsp_flat_tile,
   output logic                       rsp_tile_end
);
   import mmcs_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned OUT_W = OUT_FRAC_BITS + 1;
   localparam int unsigned CNT_W = $clog2(OUT_FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(OUT_FRAC_BITS);
   localparam logic [OUT_W-1:0] OUT_ONE  = OUT_W'(1) << OUT_FRAC_BITS;

   back_state_type     state_ff, state_in;
   logic [LEVEL_W-1:0] min_ff, min_in;
   logic [LEVEL_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0] den_ff, den_in;
   logic [OUT_W-1:0]   quo_ff, quo_in;
   logic               flat_ff, flat_in;
   logic               last_ff, last_in;
   logic               out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]   out_level_ff;
   logic               out_flat_ff;
   logic               out_end_ff;
   logic               out_load;
   logic               slot_free;
   logic               take;
   logic [LEVEL_W:0]   trial;
   logic [LEVEL_W:0]   rem_dbl;
   logic               qbit;

   assign slot_free = ~out_valid_ff | pop;
   assign q_pop     = (state_ff == ST_IDLE);
   assign take      = q_pop & ~q_status.empty;
   assign rem_dbl   = {rem_ff, 1'b0};
   assign trial     = rem_dbl - {1'b0, den_ff};
   assign qbit      = (rem_dbl >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      flat_in  = flat_ff;
      last_in  = last_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (q_item.kind == KIND_MEASURE) begin
                  if (q_item.value < min_ff) begin
                     min_in = q_item.value;
                  end
                  if (q_item.value > max_ff) begin
                     max_in = q_item.value;
                  end
               end else begin
                  state_in = ST_BUSY;
                  last_in  = q_item.last;
                  flat_in  = (max_ff <= min_ff);
                  quo_in   = '0;
                  cnt_in   = CNT_DONE;
                  rem_in   = q_item.value - min_ff;
                  den_in   = max_ff - min_ff;
                  if (max_ff <= min_ff) begin
                     quo_in = '0;
                  end else if (q_item.value <= min_ff) begin
                     quo_in = '0;
                  end else if (q_item.value >= max_ff) begin
                     quo_in = OUT_ONE;
                  end else begin
                     cnt_in = '0;
                  end
               end
            end
         end
         ST_BUSY: begin
            if (cnt_ff != CNT_DONE) begin
               cnt_in = cnt_ff + 1'b1;
               quo_in = {quo_ff[OUT_W-2:0], qbit};
               rem_in = qbit ? trial[LEVEL_W-1:0] : rem_dbl[LEVEL_W-1:0];
            end else if (slot_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (last_ff) begin
                  min_in = MIN_RESET;
                  max_in = MAX_RESET;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = (out_valid_ff & ~pop) | out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      flat_ff <= flat_in;
      last_ff <= last_in;
      if (out_load) begin
         out_level_ff <= quo_ff;
         out_flat_ff  <= flat_ff;
         out_end_ff   <= last_ff;
      end
   end

   assign empty         = ~out_valid_ff;
   assign rsp_level     = out_level_ff;
   assign rsp_flat_tile = out_flat_ff;
   assign rsp_tile_end  = out_end_ff;

   `ASSERT_NEXT(a_div_step, clock, reset, (state_ff == ST_BUSY) && (cnt_ff != CNT_DONE), cnt_ff == $past(cnt_ff) + 1'b1)
   `ASSERT_ALWAYS(a_flat_zero, clock, reset, !(out_valid_ff && out_flat_ff) || (out_level_ff == '0))
   `ASSERT_NEXT(a_hold_result, clock, reset, out_valid_ff && !pop, out_valid_ff && $stable(out_level_ff))

endmodule

// ===== rtl/minmax_contrast_stretch.sv =====
// per-tile min-max contrast stretch, top level
// depends on mmcs_pkg, mmcs_front, mmcs_queue and mmcs_back
//
// input channel: push/full with req_kind, req_pixel, req_last. a measure
// transaction (kind 0) folds the pixel level into the running min and max;
// a scale transaction (kind 1) yields one result. result channel: empty/pop
// with rsp_level, rsp_flat_tile, rsp_tile_end. csr port: one register,
// source_mode in bit 0, mapped at every address; pready is tied high.
// a four-entry queue decouples acceptance from execution. the back end
// folds in a measure transaction without leaving idle. a scale transaction
// moves it to busy, and the back end takes no new transaction until the
// result is loaded: the one-bit-a-cycle restoring divider produces
// OUT_FRAC_BITS quotient bits, while saturated and flat results skip the
// division. the result then goes to the output register once that is free,
// and empty falls.
// a stalled result waits in the output register; the back end keeps working
// on measure transactions and finishes a division, then holds until the
// result is popped. full rises when the queue fills.
// reset (synchronous) empties the queue and the output register, sets the
// minimum to 1.0, the maximum to 0 and source_mode to grey.
module minmax_contrast_stretch #(
   parameter int unsigned OUT_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_kind,
   input  logic [mmcs_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                            req_last,
   output logic                            empty,
   input  logic                            pop,
   output logic [OUT_FRAC_BITS:0]          rsp_level,
   output logic                            rsp_flat_tile,
   output logic                            rsp_tile_end,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mmcs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mmcs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mmcs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mmcs_pkg::*;

   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             q_push;
   logic             q_pop;

   mmcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_kind  (req_kind),
      .req_pixel (req_pixel),
      .req_last  (req_last),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   mmcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   mmcs_back #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_item        (head_item),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_level     (rsp_level),
      .rsp_flat_tile (rsp_flat_tile),
      .rsp_tile_end  (rsp_tile_end)
   );

endmodule
